FILE: src/inverter_safety_supervisor_defines.svh
// Assertion macros shared by the inverter safety supervisor RTL.
// Each macro samples on clk and is disabled while rst_n is low.
// Synthesis builds see empty bodies.
`ifndef INVERTER_SAFETY_SUPERVISOR_DEFINES_SVH
`define INVERTER_SAFETY_SUPERVISOR_DEFINES_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define ISS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ISS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ISS_ASSERT_ALWAYS(lbl, cond, msg)
`define ISS_ASSERT_IMPL(lbl, ante, cons, msg)
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/iss_pkg.sv
// Package for the inverter safety supervisor: codes, mode type and the
// structures passed between the input stage, the step logic and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

  // Width of the current sample bits that take part in the compare.
  localparam int CURRENT_WIDTH = 16;
  localparam logic [15:0] CUR_MASK =
    (CURRENT_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << CURRENT_WIDTH) - 32'd1);

  // Configuration register indexes and reset values.
  localparam logic CFG_IDX_LIMIT   = 1'b0;
  localparam logic CFG_IDX_CONFIRM = 1'b1;
  localparam logic [15:0] LIMIT_RESET   = 16'd5000;
  localparam logic [3:0]  CONFIRM_RESET = 4'd3;

  // Operation codes carried in the input word's user field.
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_INIT_DONE = 3'd1,
    OP_START     = 3'd2,
    OP_STOP      = 3'd3,
    OP_RESET     = 3'd4
  } op_t;

  // Supervisor state machine, one-hot.
  typedef enum logic [4:0] {
    MODE_INIT  = 5'b00001,
    MODE_IDLE  = 5'b00010,
    MODE_SWEEP = 5'b00100,
    MODE_RUN   = 5'b01000,
    MODE_FAULT = 5'b10000
  } mode_t;

  // Mode codes as reported in the result word.
  localparam logic [2:0] MCODE_INIT  = 3'd0;
  localparam logic [2:0] MCODE_IDLE  = 3'd1;
  localparam logic [2:0] MCODE_SWEEP = 3'd2;
  localparam logic [2:0] MCODE_RUN   = 3'd3;
  localparam logic [2:0] MCODE_FAULT = 3'd4;

  // Latched fault causes.
  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_INV   = 2'd1;
  localparam logic [1:0] FLT_STALE = 2'd2;
  localparam logic [1:0] FLT_OC    = 2'd3;

  // Drive commands.
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_SOFT_START = 3'd1;
  localparam logic [2:0] CMD_SOFT_STOP  = 3'd2;
  localparam logic [2:0] CMD_KILL       = 3'd3;
  localparam logic [2:0] CMD_RESET      = 3'd4;

  // Request status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LATCHED   = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_POWER_OFF = 3'd3;
  localparam logic [2:0] ST_ADC       = 3'd4;

  // LED modes.
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_BLINK = 2'd1;
  localparam logic [1:0] LED_ON    = 2'd2;

  // One input item after unpacking.
  typedef struct packed {
    logic [2:0]  op;
    logic        pwm_active;
    logic        adc_fresh;
    logic        adc_calibrated;
    logic        sample_new;
    logic [15:0] current_ma;
    logic        power_key_click;
    logic        ramp_done;
  } item_t;

  // Supervisor state held between items.
  typedef struct packed {
    mode_t      mode;
    logic [1:0] fault;
    logic [3:0] over_run;
    logic       supply;
    logic       beeper;
  } state_t;

  // Result item, declared from the highest bit down so that it packs
  // straight into the output word.
  typedef struct packed {
    logic [1:0] led_mode;
    logic       erase_allowed;
    logic       checkpoint_request;
    logic [2:0] request_status;
    logic       alarm_on;
    logic [2:0] drive_command;
    logic       power_enable;
    logic [1:0] fault_reason;
    logic [2:0] mode;
  } result_t;

endpackage

`default_nettype wire

FILE: src/inverter_safety_supervisor.sv
// Inverter safety supervisor, top level.
// Each result word passes the input register and then the result register.
// Throughput: one word per cycle; the input register and the result register
// each hand over in the cycle they are emptied, so only out_tready stalls.
// Reset (synchronous, rst_n low): mode init, no fault, supply and buzzer off,
// over-current count zero, limit 5000 mA, confirm count 3, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

`include "inverter_safety_supervisor_defines.svh"

module inverter_safety_supervisor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0 up: pwm_active, adc_fresh, adc_calibrated, sample_new,
  // current_ma[15:0], power_key_click, ramp_done, two zero bits.
  input  wire logic [23:0] in_tdata,
  // Fields from bit 0 up: operation[2:0].
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0 up: mode[2:0], fault_reason[1:0], power_enable,
  // drive_command[2:0], alarm_on, request_status[2:0], checkpoint_request,
  // erase_allowed, led_mode[1:0], seven zero bits.
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import iss_pkg::*;

  logic        stage_valid;
  item_t       stage_item;
  logic        advance;
  logic        fire;

  state_t      state_r, state_nxt;
  result_t     result;
  result_t     res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] limit_r, limit_nxt;
  logic [3:0]  confirm_r, confirm_nxt;

  // Input register.
  iss_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .take        (fire),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // Event handling.
  iss_step u_step (
    .cur_state  (state_r),
    .item       (stage_item),
    .limit      (limit_r),
    .confirm    (confirm_r),
    .next_state (state_nxt),
    .result     (result)
  );

  // A word is processed when the result register is free or being emptied.
  assign advance = !out_valid_r || out_tready;
  assign fire    = stage_valid && advance;

  // Configuration writes.
  always_comb begin
    limit_nxt   = limit_r;
    confirm_nxt = confirm_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_LIMIT:   limit_nxt   = cfg_wdata;
        CFG_IDX_CONFIRM: confirm_nxt = cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      res_nxt       = result;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode     <= MODE_INIT;
      state_r.fault    <= FLT_NONE;
      state_r.over_run <= 4'd0;
      state_r.supply   <= 1'b0;
      state_r.beeper   <= 1'b0;
      out_valid_r      <= 1'b0;
      limit_r          <= LIMIT_RESET;
      confirm_r        <= CONFIRM_RESET;
    end else begin
      if (fire) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
      confirm_r   <= confirm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r};

  // Consistency of the held state and of the result path.
  `ISS_ASSERT_ALWAYS(a_mode_onehot, $onehot(state_r.mode), "mode register is not one-hot")
  `ISS_ASSERT_IMPL(a_fault_no_supply, state_r.mode == MODE_FAULT, !state_r.supply,
    "supply is on in fault mode")
  `ISS_ASSERT_ALWAYS(a_beeper_fault, state_r.beeper == (state_r.mode == MODE_FAULT),
    "buzzer does not follow fault mode")
  `ISS_ASSERT_ALWAYS(a_latch_fault, (state_r.fault != FLT_NONE) == (state_r.mode == MODE_FAULT),
    "latched fault code disagrees with fault mode")
  `ISS_ASSERT_NEXT(a_fire_result, fire, out_valid_r, "processed word gave no result")
  `ISS_ASSERT_NEXT(a_idle_hold, !fire, $stable(state_r), "state changed with no word processed")

endmodule

`default_nettype wire

FILE: src/iss_in_stage.sv
// Input register stage of the inverter safety supervisor: accepts one word,
// unpacks it and holds it until the step logic takes it.
// Depends on iss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iss_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // Fields from bit 0 up: pwm_active, adc_fresh, adc_calibrated, sample_new,
  // current_ma[15:0], power_key_click, ramp_done, two zero bits.
  input  wire logic [23:0]   in_tdata,
  // Fields from bit 0 up: operation[2:0].
  input  wire logic [2:0]    in_tuser,
  input  wire logic          take,
  output logic               stage_valid,
  output iss_pkg::item_t     stage_item
);
  import iss_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  // The stage frees itself in the same cycle that its word is taken.
  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  // Unpack the incoming word.
  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      item_nxt.op              = in_tuser;
      item_nxt.pwm_active      = in_tdata[0];
      item_nxt.adc_fresh       = in_tdata[1];
      item_nxt.adc_calibrated  = in_tdata[2];
      item_nxt.sample_new      = in_tdata[3];
      item_nxt.current_ma      = in_tdata[19:4];
      item_nxt.power_key_click = in_tdata[20];
      item_nxt.ramp_done       = in_tdata[21];
    end
  end

  // Occupancy of the stage.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

`default_nettype wire

FILE: src/iss_step.sv
// Step logic of the inverter safety supervisor: from the current state, the
// configuration and one item it forms the next state and the result item.
// Purely combinational; depends on iss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iss_step (
  input  wire iss_pkg::state_t cur_state,
  input  wire iss_pkg::item_t  item,
  input  wire logic [15:0]     limit,
  input  wire logic [3:0]      confirm,
  output iss_pkg::state_t      next_state,
  output iss_pkg::result_t     result
);
  import iss_pkg::*;

  // State plus the per-item outputs that the helpers below modify.
  typedef struct packed {
    state_t     st;
    logic [2:0] cmd;
    logic       ckpt;
  } work_t;

  function automatic logic is_active(mode_t m);
    return (m == MODE_SWEEP) || (m == MODE_RUN);
  endfunction

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_INIT:  code = MCODE_INIT;
      MODE_IDLE:  code = MCODE_IDLE;
      MODE_SWEEP: code = MCODE_SWEEP;
      MODE_RUN:   code = MCODE_RUN;
      MODE_FAULT: code = MCODE_FAULT;
      default:    code = MCODE_INIT;
    endcase
    return code;
  endfunction

  // A checkpoint is requested when an active mode is left for a passive one.
  function automatic work_t set_mode(work_t w, mode_t m);
    if (m != w.st.mode) begin
      if (is_active(w.st.mode) && !is_active(m)) begin
        w.ckpt = 1'b1;
      end
      w.st.mode = m;
    end
    return w;
  endfunction

  // Only the first cause of a fault is latched.
  function automatic work_t raise_fault(work_t w, logic [1:0] code);
    if (w.st.fault == FLT_NONE) begin
      w.st.fault = code;
    end
    w.cmd       = CMD_KILL;
    w.st.supply = 1'b0;
    w           = set_mode(w, MODE_FAULT);
    w.st.beeper = 1'b1;
    return w;
  endfunction

  // Power, PWM and mode must agree.
  function automatic logic invariant_bad(state_t s, logic pwm);
    return (!s.supply && pwm) ||
           ((s.mode == MODE_IDLE) && pwm) ||
           (is_active(s.mode) && (!s.supply || !pwm)) ||
           ((s.mode == MODE_FAULT) && (s.supply || pwm));
  endfunction

  function automatic work_t do_stop(work_t w);
    if (w.st.mode == MODE_FAULT) begin
      w.cmd       = CMD_KILL;
      w.st.supply = 1'b0;
    end else if (w.st.mode != MODE_INIT) begin
      w.cmd = CMD_SOFT_STOP;
      if (is_active(w.st.mode)) begin
        w = set_mode(w, MODE_IDLE);
      end
    end
    return w;
  endfunction

  work_t       w;
  logic [2:0]  status;
  logic [15:0] cur_used;
  mode_t       start_mode;

  assign cur_used = item.current_ma & CUR_MASK;

  // One pass through the event handling.
  always_comb begin
    w.st       = cur_state;
    w.cmd      = CMD_NONE;
    w.ckpt     = 1'b0;
    status     = ST_OK;
    start_mode = cur_state.mode;
    unique case (op_t'(item.op))
      OP_TICK: begin
        if (w.st.mode != MODE_INIT) begin
          // Invariant check, then the current monitor.
          if (invariant_bad(w.st, item.pwm_active)) begin
            w = raise_fault(w, FLT_INV);
          end
          if (is_active(w.st.mode) && !item.adc_fresh) begin
            w = raise_fault(w, FLT_STALE);
          end else if (item.sample_new) begin
            if (!is_active(w.st.mode)) begin
              w.st.over_run = 4'd0;
            end else if (cur_used > limit) begin
              if (w.st.over_run < confirm) begin
                w.st.over_run = 4'(w.st.over_run + 4'd1);
              end
              if (w.st.over_run >= confirm) begin
                w = raise_fault(w, FLT_OC);
              end
            end else begin
              w.st.over_run = 4'd0;
            end
          end
          // Power key toggles the supply; with a fault latched, or an illegal switch-on, it kills the drive.
          if (item.power_key_click) begin
            if ((w.st.mode == MODE_FAULT) || (w.st.fault != FLT_NONE)) begin
              w.cmd       = CMD_KILL;
              w.st.supply = 1'b0;
            end else if (!w.st.supply) begin
              if ((w.st.mode == MODE_IDLE) && !item.pwm_active) begin
                w.st.supply = 1'b1;
              end else begin
                w = raise_fault(w, FLT_INV);
              end
            end else begin
              w           = do_stop(w);
              w.st.supply = 1'b0;
            end
          end
          // Soft start finished.
          if ((start_mode == MODE_SWEEP) && (w.st.mode == MODE_SWEEP) && item.ramp_done) begin
            w = set_mode(w, MODE_RUN);
          end
        end
      end
      OP_INIT_DONE: begin
        if (w.st.mode == MODE_INIT) begin
          w = set_mode(w, MODE_IDLE);
        end else begin
          status = ST_INVALID;
        end
      end
      OP_START: begin
        if ((w.st.mode == MODE_FAULT) || (w.st.fault != FLT_NONE)) begin
          status = ST_LATCHED;
        end else if (is_active(w.st.mode)) begin
          if (invariant_bad(w.st, item.pwm_active)) begin
            w      = raise_fault(w, FLT_INV);
            status = ST_INVALID;
          end
        end else if (w.st.mode != MODE_IDLE) begin
          status = ST_INVALID;
        end else if (!w.st.supply) begin
          status = ST_POWER_OFF;
        end else if (!item.adc_calibrated || !item.adc_fresh) begin
          status = ST_ADC;
        end else begin
          w     = set_mode(w, MODE_SWEEP);
          w.cmd = CMD_SOFT_START;
        end
      end
      OP_STOP: begin
        if (w.st.mode == MODE_INIT) begin
          status = ST_INVALID;
        end else if (w.st.mode == MODE_FAULT) begin
          status = ST_LATCHED;
        end
        w = do_stop(w);
      end
      OP_RESET: begin
        if (w.st.mode != MODE_FAULT) begin
          status = ST_INVALID;
        end else begin
          w.cmd         = CMD_RESET;
          w.st.supply   = 1'b0;
          w.st.beeper   = 1'b0;
          w.st.over_run = 4'd0;
          w.st.fault    = FLT_NONE;
          w             = set_mode(w, MODE_IDLE);
        end
      end
      default: begin
        // Unknown operations leave everything as it is.
      end
    endcase
  end

  // Result fields are taken after the step.
  always_comb begin
    next_state                = w.st;
    result.mode               = mode_code(w.st.mode);
    result.fault_reason       = w.st.fault;
    result.power_enable       = w.st.supply;
    result.drive_command      = w.cmd;
    result.alarm_on           = w.st.beeper;
    result.request_status     = status;
    result.checkpoint_request = w.ckpt;
    result.erase_allowed      = !is_active(w.st.mode);
    result.led_mode           = (w.st.mode == MODE_SWEEP) ? LED_BLINK :
                                (w.st.mode == MODE_RUN) ? LED_ON : LED_OFF;
  end

endmodule

`default_nettype wire

FILE: test/iss_result_checker.sv
// Result checker for the inverter safety supervisor testbench.
// Watches the input, result and configuration ports, predicts every result word
// and compares it field by field. Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_result_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // Fields from bit 0 up: pwm_active, adc_fresh, adc_calibrated, sample_new,
  // current_ma[15:0], power_key_click, ramp_done, two zero bits.
  input  wire logic [23:0] in_tdata,
  // Fields from bit 0 up: operation[2:0].
  input  wire logic [2:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0 up: mode, fault_reason, power_enable, drive_command,
  // alarm_on, request_status, checkpoint_request, erase_allowed, led_mode.
  input  wire logic [23:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               words_due
);

  import iss_pkg::*;

  // Configuration as seen on the write port.
  logic [15:0] lim_ma;
  logic [3:0]  trip_after;

  // Supervisor state after every accepted input word.
  logic [2:0]  mode_q;
  logic [1:0]  fault_q;
  logic [3:0]  over_q;
  logic        supply_q;
  logic        beep_q;

  // Per-word side outputs.
  logic [2:0]  cmd_now;
  logic        left_active;

  result_t     reports_due[$];
  int          err_total = 0;

  function automatic bit is_active(input logic [2:0] m);
    return m == MCODE_SWEEP || m == MCODE_RUN;
  endfunction

  // Leaving sweep or running for a passive mode asks for a checkpoint.
  function automatic void enter_mode(input logic [2:0] m);
    if (m == mode_q) return;
    if (is_active(mode_q) && !is_active(m)) left_active = 1'b1;
    mode_q = m;
  endfunction

  // Only the first cause is latched; every fault kills the drive.
  function automatic void trip(input logic [1:0] cause);
    if (fault_q == FLT_NONE) fault_q = cause;
    cmd_now  = CMD_KILL;
    supply_q = 1'b0;
    enter_mode(MCODE_FAULT);
    beep_q   = 1'b1;
  endfunction

  function automatic bit invariant_ok(input logic pwm);
    bit bad;
    bad = (!supply_q && pwm) || (mode_q == MCODE_IDLE && pwm) ||
          (is_active(mode_q) && (!supply_q || !pwm)) ||
          (mode_q == MCODE_FAULT && (supply_q || pwm));
    if (bad) trip(FLT_INV);
    return !bad;
  endfunction

  function automatic logic [2:0] stop_req();
    if (mode_q == MCODE_INIT) return ST_INVALID;
    if (mode_q == MCODE_FAULT) begin
      cmd_now  = CMD_KILL;
      supply_q = 1'b0;
      return ST_LATCHED;
    end
    cmd_now = CMD_SOFT_STOP;
    if (is_active(mode_q)) enter_mode(MCODE_IDLE);
    return ST_OK;
  endfunction

  function automatic logic [2:0] start_req(input logic pwm, input logic fresh,
                                           input logic cal);
    if (mode_q == MCODE_FAULT || fault_q != FLT_NONE) return ST_LATCHED;
    if (is_active(mode_q)) return invariant_ok(pwm) ? ST_OK : ST_INVALID;
    if (mode_q != MCODE_IDLE) return ST_INVALID;
    if (!supply_q) return ST_POWER_OFF;
    if (!cal || !fresh) return ST_ADC;
    enter_mode(MCODE_SWEEP);
    cmd_now = CMD_SOFT_START;
    return ST_OK;
  endfunction

  function automatic logic [2:0] clear_fault();
    if (mode_q != MCODE_FAULT) return ST_INVALID;
    cmd_now  = CMD_RESET;
    supply_q = 1'b0;
    beep_q   = 1'b0;
    over_q   = '0;
    fault_q  = FLT_NONE;
    enter_mode(MCODE_IDLE);
    return ST_OK;
  endfunction

  // Monitor tick: invariant, then over-current, then power key, then ramp end.
  function automatic void monitor_tick(input item_t w);
    logic [2:0]  entry_mode;
    logic [15:0] cur;
    entry_mode = mode_q;
    cur = w.current_ma & CUR_MASK;
    if (mode_q == MCODE_INIT) return;
    void'(invariant_ok(w.pwm_active));

    if (is_active(mode_q) && !w.adc_fresh) begin
      trip(FLT_STALE);
    end else if (w.sample_new) begin
      if (!is_active(mode_q)) begin
        over_q = '0;
      end else if (cur > lim_ma) begin
        if (over_q < trip_after) over_q = over_q + 4'd1;
        if (over_q >= trip_after) trip(FLT_OC);
      end else begin
        over_q = '0;
      end
    end

    if (w.power_key_click) begin
      if (mode_q == MCODE_FAULT || fault_q != FLT_NONE) begin
        cmd_now  = CMD_KILL;
        supply_q = 1'b0;
      end else if (!supply_q) begin
        if (mode_q == MCODE_IDLE && !w.pwm_active) supply_q = 1'b1;
        else trip(FLT_INV);
      end else begin
        void'(stop_req());
        supply_q = 1'b0;
      end
    end

    if (entry_mode == MCODE_SWEEP && mode_q == MCODE_SWEEP && w.ramp_done)
      enter_mode(MCODE_RUN);
  endfunction

  // Advances the supervisor by one word and returns the result it reports.
  function automatic result_t supervise_word(input item_t w);
    result_t    r;
    logic [2:0] status;
    cmd_now     = CMD_NONE;
    left_active = 1'b0;
    status      = ST_OK;
    case (w.op)
      OP_TICK:      monitor_tick(w);
      OP_INIT_DONE: begin
        if (mode_q == MCODE_INIT) enter_mode(MCODE_IDLE);
        else status = ST_INVALID;
      end
      OP_START:     status = start_req(w.pwm_active, w.adc_fresh, w.adc_calibrated);
      OP_STOP:      status = stop_req();
      OP_RESET:     status = clear_fault();
      default:      ;
    endcase
    r.mode               = mode_q;
    r.fault_reason       = fault_q;
    r.power_enable       = supply_q;
    r.drive_command      = cmd_now;
    r.alarm_on           = beep_q;
    r.request_status     = status;
    r.checkpoint_request = left_active;
    r.erase_allowed      = !is_active(mode_q);
    r.led_mode           = (mode_q == MCODE_SWEEP) ? LED_BLINK :
                           (mode_q == MCODE_RUN) ? LED_ON : LED_OFF;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      err_total++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, field, want, seen);
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    result_t seen;
    if (!rst_n) begin
      lim_ma     = LIMIT_RESET;
      trip_after = CONFIRM_RESET;
      mode_q     = MCODE_INIT;
      fault_q    = FLT_NONE;
      over_q     = '0;
      supply_q   = 1'b0;
      beep_q     = 1'b0;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_LIMIT) lim_ma = cfg_wdata;
        else trip_after = cfg_wdata[3:0];
      end

      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[16:0]);
        if (reports_due.size() == 0) begin
          err_total++;
          $display("%0t ns: result word with none expected, expected nothing, actual %h",
                   $time, out_tdata);
        end else begin
          want = reports_due.pop_front();
          check_field("mode", want.mode, seen.mode);
          check_field("fault_reason", want.fault_reason, seen.fault_reason);
          check_field("power_enable", want.power_enable, seen.power_enable);
          check_field("drive_command", want.drive_command, seen.drive_command);
          check_field("alarm_on", want.alarm_on, seen.alarm_on);
          check_field("request_status", want.request_status, seen.request_status);
          check_field("checkpoint_request", want.checkpoint_request,
                      seen.checkpoint_request);
          check_field("erase_allowed", want.erase_allowed, seen.erase_allowed);
          check_field("led_mode", want.led_mode, seen.led_mode);
        end
      end

      if (in_tvalid && in_tready) begin
        w.op              = in_tuser;
        w.pwm_active      = in_tdata[0];
        w.adc_fresh       = in_tdata[1];
        w.adc_calibrated  = in_tdata[2];
        w.sample_new      = in_tdata[3];
        w.current_ma      = in_tdata[19:4];
        w.power_key_click = in_tdata[20];
        w.ramp_done       = in_tdata[21];
        reports_due.push_back(supervise_word(w));
      end
    end
    fail_count <= err_total;
    words_due  <= reports_due.size();
  end

endmodule

FILE: test/inverter_safety_supervisor_tb.sv
// Top of the inverter safety supervisor testbench: clock, reset, stimulus and
// verdict. Depends on iss_pkg, the supervisor RTL and iss_result_checker.
`timescale 1ns / 1ps

module inverter_safety_supervisor_tb;

  import iss_pkg::*;

  localparam int CLK_NS        = 8;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_WORDS   = 85;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 6;

  // Operation codes the block does not define; it must answer them with no action.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // How a powered session is brought to an end.
  localparam int END_STOP     = 0;
  localparam int END_KEY      = 1;
  localparam int END_STALE    = 2;
  localparam int END_BURST    = 3;
  localparam int END_PWM_LOSS = 4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int          check_errors;
  int          check_pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          want_hold;
  logic [15:0] oc_limit;
  logic [3:0]  oc_confirm;
  int          words_sent;
  int          cycles;

  inverter_safety_supervisor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  iss_result_checker results_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (check_errors),
    .words_due  (check_pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_NS / 2) clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off when asked.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic item_t mk(input logic [2:0] op, input logic pwm,
                               input logic fresh, input logic cal,
                               input logic smp, input logic [15:0] cur,
                               input logic key, input logic ramp);
    item_t w;
    w.op              = op;
    w.pwm_active      = pwm;
    w.adc_fresh       = fresh;
    w.adc_calibrated  = cal;
    w.sample_new      = smp;
    w.current_ma      = cur;
    w.power_key_click = key;
    w.ramp_done       = ramp;
    return w;
  endfunction

  function automatic item_t any_fields(input logic [2:0] op);
    return mk(op, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
              16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)),
              1'($urandom_range(1, 0)));
  endfunction

  function automatic logic [2:0] noise_op();
    if ($urandom_range(99) < 6) return 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    return 3'($urandom_range(OP_RESET, OP_TICK));
  endfunction

  // A limit of all ones leaves no current above it.
  function automatic logic [15:0] over_current();
    if (oc_limit == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(65535, int'(oc_limit) + 1));
  endfunction

  function automatic logic [15:0] under_current();
    return 16'($urandom_range(oc_limit, 0));
  endfunction

  // Presents one word and returns in the time step in which it was taken.
  task automatic offer(input item_t w);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.op;
    in_tdata  <= {2'b00, w.ramp_done, w.power_key_click, w.current_ma,
                  w.sample_new, w.adc_calibrated, w.adc_fresh, w.pwm_active};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Sometimes slips a random word in ahead of the intended one.
  task automatic offer_mixed(input item_t w);
    if ($urandom_range(99) < 8) offer(any_fields(noise_op()));
    offer(w);
  endtask

  // Waits until every expected word has come back and the block is quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] limit, input logic [3:0] confirm);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= CFG_IDX_CONFIRM;
    cfg_wdata <= {12'd0, confirm};
    @(posedge clk);
    cfg_we     <= 1'b0;
    oc_limit   = limit;
    oc_confirm = confirm;
  endtask

  // One powered session: supply on, start, sweep, run, then some way out.
  task automatic run_session();
    item_t w;
    int    sweep_ticks;
    int    run_ticks;
    int    finish_kind;
    sweep_ticks = $urandom_range(4, 1);
    run_ticks   = $urandom_range(10, 2);
    finish_kind = $urandom_range(END_PWM_LOSS, END_STOP);
    if (finish_kind == END_BURST && oc_limit == 16'hFFFF) finish_kind = END_STOP;

    // Clear whatever fault is left, then switch the supply on.
    offer(any_fields(OP_RESET));
    w = any_fields(OP_TICK);
    w.pwm_active      = 1'b0;
    w.adc_fresh       = 1'b1;
    w.power_key_click = 1'b1;
    offer_mixed(w);

    // Mostly a start with the ADC ready.
    w = any_fields(OP_START);
    if ($urandom_range(9) != 0) begin
      w.adc_fresh      = 1'b1;
      w.adc_calibrated = 1'b1;
    end
    offer_mixed(w);

    for (int i = 0; i < sweep_ticks; i++) begin
      w = any_fields(OP_TICK);
      w.pwm_active      = 1'b1;
      w.adc_fresh       = 1'b1;
      w.power_key_click = 1'b0;
      w.current_ma      = under_current();
      w.ramp_done       = (i == sweep_ticks - 1);
      offer_mixed(w);
    end

    // Running: mostly samples below the limit, a few above it.
    for (int i = 0; i < run_ticks; i++) begin
      w = any_fields(OP_TICK);
      w.pwm_active      = 1'b1;
      w.adc_fresh       = 1'b1;
      w.power_key_click = 1'b0;
      w.sample_new      = ($urandom_range(4) != 0);
      w.current_ma      = ($urandom_range(3) == 0) ? over_current() : under_current();
      offer_mixed(w);
    end

    case (finish_kind)
      END_STOP: begin
        offer_mixed(any_fields(OP_STOP));
        w = any_fields(OP_TICK);
        w.pwm_active      = 1'b0;
        w.power_key_click = 1'b1;
        offer_mixed(w);
      end
      END_KEY: begin
        offer_mixed(mk(OP_TICK, 1'b1, 1'b1, 1'($urandom_range(1, 0)), 1'b0,
                       under_current(), 1'b1, 1'b0));
      end
      END_STALE: begin
        w = any_fields(OP_TICK);
        w.pwm_active      = 1'b1;
        w.adc_fresh       = 1'b0;
        w.power_key_click = 1'b0;
        offer_mixed(w);
      end
      END_BURST: begin
        repeat (int'(oc_confirm) + 1)
          offer(mk(OP_TICK, 1'b1, 1'b1, 1'($urandom_range(1, 0)), 1'b1,
                   over_current(), 1'b0, 1'($urandom_range(1, 0))));
      end
      default: begin
        w = any_fields(OP_TICK);
        w.pwm_active      = 1'b0;
        w.adc_fresh       = 1'b1;
        w.power_key_click = 1'b0;
        offer_mixed(w);
      end
    endcase

    // Linger in the resulting state and try a start there.
    w = any_fields(OP_TICK);
    w.pwm_active      = 1'b0;
    w.power_key_click = 1'b0;
    offer_mixed(w);
    offer_mixed(any_fields(OP_START));
  endtask

  initial begin : stimulus
    int phase_start;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = OP_TICK;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IDX_LIMIT;
    cfg_wdata   = '0;
    tx_idle_pct = 26;
    rx_idle_pct = 51;
    want_hold   = 1'b0;
    oc_limit    = LIMIT_RESET;
    oc_confirm  = CONFIRM_RESET;
    words_sent  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through every mode with the reset configuration.
    offer(mk(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));  // ignored in init
    offer(mk(OP_START, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_UNUSED_HI, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));
    offer(mk(OP_INIT_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_INIT_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_START, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));    // supply off
    offer(mk(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0));     // supply on
    offer(mk(OP_START, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));    // not calibrated
    offer(mk(OP_START, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));    // stale ADC
    offer(mk(OP_START, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));    // into sweep
    offer(mk(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b1));     // into running
    offer(mk(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b1, LIMIT_RESET, 1'b0, 1'b0));  // at the limit
    offer(mk(OP_START, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));    // already active
    repeat (3) offer(mk(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b1, LIMIT_RESET + 16'd1, 1'b0, 1'b0));
    offer(mk(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0));     // key in fault
    offer(mk(OP_START, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_STOP, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0));
    offer(mk(OP_START, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b1));     // ADC goes stale
    offer(mk(OP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0));
    offer(mk(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0));     // PWM with no supply

    // Random sessions under changing limits and flow control.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: write_config(16'd0, 4'd1);
        1: write_config(16'hFFFF, 4'd15);
        2: write_config(16'd1000, 4'd0);    // the first sample above the limit trips
        3: write_config(16'($urandom_range(20000, 100)), 4'($urandom_range(15, 1)));
        4: write_config(LIMIT_RESET, CONFIRM_RESET);
        default: write_config(16'($urandom_range(65534, 0)), 4'($urandom_range(4, 1)));
      endcase
      if (phase < 2) begin
        tx_idle_pct = 26;
        rx_idle_pct <= 51;
      end else if (phase < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct <= 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (phase == 4) want_hold <= 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) run_session();
    end

    settle();
    if (check_errors == 0 && check_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/iss_pkg.sv
src/iss_in_stage.sv
src/iss_step.sv
src/inverter_safety_supervisor.sv
test/iss_result_checker.sv
test/inverter_safety_supervisor_tb.sv
